/* rtl/sorted_array_table_defines.svh */
// ----------------------------------------------------------------------------
// Sorted array table assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_TABLE_DEFINES_SVH
`define SORTED_ARRAY_TABLE_DEFINES_SVH

// Checked only while reset is released.
`define SAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted array table package
// Field widths, operation and status codes, and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  localparam int unsigned SAT_DEPTH      = 16;
  localparam int unsigned SAT_DATA_WIDTH = 32;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2
  } sat_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } sat_status_e;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } sat_cell_ctrl_t;

  // Status of the search unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } sat_srch_rsp_t;

endpackage

`default_nettype wire

/* rtl/sat_in_if.sv */
// ----------------------------------------------------------------------------
// Sorted array table request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_in_if
  import sat_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [IDX_W-1:0]          index;

  modport source (output valid, output func, output value, output index, input ready);
  modport sink   (input valid, input func, input value, input index, output ready);
endinterface

`default_nettype wire

/* rtl/sat_out_if.sv */
// ----------------------------------------------------------------------------
// Sorted array table response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_out_if
  import sat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

`default_nettype wire

/* rtl/sat_cell.sv */
// ----------------------------------------------------------------------------
// Sorted array table cell
// Holds one entry, compares it with the request value and shifts it to or
// from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_cell
  import sat_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = SAT_DATA_WIDTH,
  parameter int unsigned CW         = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                         clk_i,
  input  sat_cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic signed [DATA_WIDTH-1:0] left_entry_i,
  input  logic signed [DATA_WIDTH-1:0] right_entry_i,
  input  logic                         left_gt_i,
  input  logic [CW-1:0]                count_i,
  input  logic [IDX_W-1:0]             index_i,
  output logic signed [DATA_WIDTH-1:0] entry_o,
  output logic                         gt_o,
  output logic                         ge_o
);

  logic signed [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                         occupied;
  logic                         rem_sel;

  assign occupied = int'(IDX) < int'(count_i);
  assign rem_sel  = int'(IDX) >= int'(index_i);

  // Empty cells count as greater so the insert boundary lands on the first free one.
  assign gt_o = !occupied || (entry_q > value_i);
  assign ge_o = !occupied || (entry_q >= value_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && gt_o) begin
      entry_d = left_gt_i ? left_entry_i : value_i;
    end else if (ctrl_i.rem && rem_sel) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* rtl/sat_search.sv */
// ----------------------------------------------------------------------------
// Sorted array table search unit
// Replays the binary search one midpoint per cycle against the bounds of the
// run of entries equal to the key.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_search
  import sat_pkg::*;
#(
  parameter int unsigned CW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          hold_i,
  input  logic [CW-1:0] low_bound_i,
  input  logic [CW-1:0] high_bound_i,
  input  logic [CW-1:0] count_i,
  output sat_srch_rsp_t rsp_o,
  output logic [CW-1:0] pos_o
);

  localparam int unsigned SW = CW + 1;

  logic          busy_q, busy_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hip_q, hip_d;
  logic [CW-1:0] lb_q, lb_d;
  logic [CW-1:0] hb_q, hb_d;
  logic [SW-1:0] mid_sum;
  logic [CW-1:0] mid;
  logic          empty;
  logic          below;
  logic          above;
  logic          done;

  // hip holds high + 1, so the range is empty when lo reaches it.
  assign empty   = lo_q >= hip_q;
  assign mid_sum = SW'(lo_q) + SW'(hip_q) - SW'(1);
  assign mid     = CW'(mid_sum >> 1);
  assign below   = mid < lb_q;
  assign above   = mid >= hb_q;
  assign done    = busy_q && (empty || (!below && !above));

  always_comb begin
    busy_d = busy_q;
    lo_d   = lo_q;
    hip_d  = hip_q;
    lb_d   = lb_q;
    hb_d   = hb_q;
    if (start_i) begin
      busy_d = 1'b1;
      lo_d   = '0;
      hip_d  = count_i;
      lb_d   = low_bound_i;
      hb_d   = high_bound_i;
    end else if (busy_q) begin
      priority if (done) begin
        busy_d = hold_i;
      end else if (below) begin
        lo_d = CW'(mid + 1'b1);
      end else begin
        hip_d = mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hip_q <= hip_d;
    lb_q  <= lb_d;
    hb_q  <= hb_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done;
  assign rsp_o.hit  = !empty;
  assign pos_o      = mid;

endmodule

`default_nettype wire

/* rtl/sorted_array_table.sv */
// Insert and remove: result word registered in the cycle after acceptance, one word per cycle
// while the output slot is not held. Search: result word set by the search unit that tries
// one midpoint per cycle; no new word is taken meanwhile.
// Reset clears the entry count and the control state; entry contents are not reset.
// ----------------------------------------------------------------------------
// Sorted array table
// Ascending table of signed entries held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_array_table_defines.svh"

module sorted_array_table
  import sat_pkg::*;
#(
  parameter int unsigned DEPTH      = SAT_DEPTH,
  parameter int unsigned DATA_WIDTH = SAT_DATA_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sat_in_if.sink     req_i,
  sat_out_if.source  rsp_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = CW + IDX_W;

  // Request decode. The incoming value is resized to the entry width with its sign.
  logic                         acc;
  logic                         is_ins, is_rem, is_srch;
  logic                         full;
  logic                         rem_ok;
  logic                         ins_go, rem_go;
  logic signed [DATA_WIDTH-1:0] value_w;
  sat_cell_ctrl_t               cell_ctrl;

  logic [CW-1:0]                count_q, count_d;

  // Cell chain taps. The extra flag past the last cell is a virtual cell
  // that is always greater, so the boundary search always finds an edge.
  logic signed [DATA_WIDTH-1:0] entry_w [DEPTH];
  logic                         gt_w    [DEPTH+1];
  logic                         ge_w    [DEPTH+1];
  logic [CW-1:0]                ins_pos;
  logic [CW-1:0]                low_pos;

  sat_srch_rsp_t                srch_rsp;
  logic [CW-1:0]                srch_pos;
  logic                         hold;
  logic                         srch_wr;
  logic                         direct_wr;

  // Output register.
  logic                         out_valid_q;
  sat_status_e                  status_q, status_d;
  logic [CW-1:0]                pos_q, pos_d;
  logic [CW-1:0]                cnt_out_q, cnt_out_d;

  assign acc     = req_i.valid && req_i.ready;
  assign is_ins  = req_i.func == FUNC_INSERT;
  assign is_rem  = req_i.func == FUNC_REMOVE;
  assign is_srch = req_i.func == FUNC_SEARCH;
  assign full    = count_q == CW'(DEPTH);
  assign rem_ok  = CMPW'(req_i.index) < CMPW'(count_q);
  assign ins_go  = acc && is_ins && !full;
  assign rem_go  = acc && is_rem && rem_ok;
  assign value_w = DATA_WIDTH'(req_i.value);

  assign cell_ctrl.ins = ins_go;
  assign cell_ctrl.rem = rem_go;

  // The output slot is busy when it holds a word that is not being taken.
  assign hold = out_valid_q && !rsp_o.ready;

  // A word is taken only when no search is running and the output slot frees up.
  assign req_i.ready = !srch_rsp.busy && !hold;

  // Each cell holds one entry. On insert, every cell above the insert point
  // takes its left neighbor's entry and the boundary cell takes the new value.
  // On remove, every cell at or above the index takes its right neighbor's entry.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_entry;
    logic signed [DATA_WIDTH-1:0] right_entry;
    logic                         left_gt;

    if (k == 0) begin : g_first
      assign left_entry = value_w;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_entry = entry_w[k-1];
      assign left_gt    = gt_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_entry = entry_w[k];
    end else begin : g_body
      assign right_entry = entry_w[k+1];
    end

    sat_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .IDX        (k)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .value_i       (value_w),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .left_gt_i     (left_gt),
      .count_i       (count_q),
      .index_i       (req_i.index),
      .entry_o       (entry_w[k]),
      .gt_o          (gt_w[k]),
      .ge_o          (ge_w[k])
    );
  end

  assign gt_w[DEPTH] = 1'b1;
  assign ge_w[DEPTH] = 1'b1;

  // The greater and greater-or-equal flags rise once along the chain. The
  // rising edge of the first gives the insert position, which is also the end
  // of the run of entries equal to the value; the second gives its start.
  always_comb begin
    ins_pos = '0;
    low_pos = '0;
    for (int k = 1; k <= int'(DEPTH); k++) begin
      if (gt_w[k] && !gt_w[k-1]) begin
        ins_pos = ins_pos | CW'(k);
      end
      if (ge_w[k] && !ge_w[k-1]) begin
        low_pos = low_pos | CW'(k);
      end
    end
  end

  // The search unit walks the midpoints over the run bounds captured here.
  sat_search #(
    .CW (CW)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (acc && is_srch),
    .hold_i       (hold),
    .low_bound_i  (low_pos),
    .high_bound_i (ins_pos),
    .count_i      (count_q),
    .rsp_o        (srch_rsp),
    .pos_o        (srch_pos)
  );

  assign srch_wr   = srch_rsp.done && !hold;
  assign direct_wr = acc && !is_srch;

  always_comb begin
    count_d = count_q;
    if (ins_go) begin
      count_d = count_q + 1'b1;
    end else if (rem_go) begin
      count_d = count_q - 1'b1;
    end
  end

  // Result word for the operation finishing this cycle.
  always_comb begin
    status_d  = ST_DONE;
    pos_d     = '0;
    cnt_out_d = count_d;
    if (srch_wr) begin
      if (srch_rsp.hit) begin
        pos_d = srch_pos;
      end else begin
        status_d = ST_MISS;
      end
    end else begin
      unique case (sat_func_e'(req_i.func))
        FUNC_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            pos_d = ins_pos;
          end
        end
        FUNC_REMOVE: begin
          if (rem_ok) begin
            pos_d = CW'(req_i.index);
          end else begin
            status_d = ST_RANGE;
          end
        end
        default: begin
          // The unused operation code changes nothing and reports done.
          status_d = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (srch_wr || direct_wr) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (srch_wr || direct_wr) begin
      status_q  <= status_d;
      pos_q     <= pos_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.position = POS_W'(pos_q);
  assign rsp_o.count    = CNT_W'(cnt_out_q);

  // The stored count never passes the table depth.
  `SAT_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  // An accepted insert into a table with room grows the count by one.
  `SAT_ASSERT(a_ins_grows, ins_go |=> count_q == $past(count_q) + 1'b1, "insert did not grow count")
  // An accepted in-range remove shrinks the count by one.
  `SAT_ASSERT(a_rem_shrinks, rem_go |=> count_q == $past(count_q) - 1'b1, "remove did not shrink count")
  // A search result and a direct result never compete for the output slot.
  `SAT_ASSERT(a_no_collide, !(srch_wr && direct_wr), "search and direct result collide")
  // Any word other than done carries position zero.
  `SAT_ASSERT(a_reject_pos, rsp_o.valid && rsp_o.status != ST_DONE |-> rsp_o.position == '0, "nonzero position on reject")

endmodule

`default_nettype wire
